[hw/rtl/abfc_pkg.sv]
// ----------------------------------------------------------------------------
// abfc_pkg
// Shared types and constants for the alpha blend / FNV-1a checksum block.
// ----------------------------------------------------------------------------
package abfc_pkg;

   // field widths
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned HASH_W     = 64;
   localparam int unsigned PROD_W     = 2 * CHAN_W;
   localparam int unsigned NUM_LANES  = 3;
   localparam int unsigned REQ_DATA_W = 7 * CHAN_W;
   localparam int unsigned RSP_DATA_W = NUM_LANES * CHAN_W + HASH_W;

   // blend constants
   localparam logic [CHAN_W-1:0] ALPHA_MAX   = 8'd255;
   localparam logic [PROD_W:0]   BLEND_ROUND = 17'd127;

   // hash start value; differs from the standard fnv-1a 64 offset basis
   localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'd1469598103934665603;

   // byte order folded into the hash
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;
   localparam logic [1:0] SEL_ALPHA = 2'd3;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FOLD,
      ST_DONE
   } abfc_state_type;

   // control from the sequencer to the hash unit
   typedef struct packed {
      logic fold;
      logic clear;
   } abfc_hash_ctrl_type;

endpackage

[hw/rtl/alpha_blend_fnv_checksum.sv]
// ----------------------------------------------------------------------------
// alpha_blend_fnv_checksum
// Alpha blend of RGBA over RGB with a running FNV-1a 64 image checksum.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per word and returns one blended pixel with
// the checksum so far. Three channel lanes blend red, green and blue side by
// side (multiply, then round and divide by 255), and the hash unit then folds
// the bytes R, G, B and 255 into the running FNV-1a 64 value, one byte per
// cycle. A new word is accepted only once the previous one is through its
// steps: the products, the divide, four byte folds and the load of the result
// register, which waits while the previous result is still unread. Each
// pixel's hash starts from the previous pixel's. The result may wait in its
// register while the next word is already being worked on. After the word
// marked last the checksum returns to the offset basis.
// ----------------------------------------------------------------------------
module alpha_blend_fnv_checksum (
   input  logic                                clock,
   input  logic                                reset,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue
   input  logic [abfc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,   // last_pixel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // out_red, out_green, out_blue, running_hash
   output logic [abfc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,   // image_done
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   localparam int unsigned CW = abfc_pkg::CHAN_W;

   abfc_pkg::abfc_state_type     state_ff, state_in;
   logic [1:0]                   sel_ff, sel_in;
   logic                         last_ff;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [abfc_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                         rsp_tlast_ff;

   logic                         req_accept;
   logic                         out_free;
   logic                         out_load;
   logic                         lane_load;
   logic                         lane_calc;
   abfc_pkg::abfc_hash_ctrl_type hash_ctrl;
   logic [CW-1:0]                fold_byte;
   logic [abfc_pkg::HASH_W-1:0]  hash;
   logic [CW-1:0]                src_chan [abfc_pkg::NUM_LANES];
   logic [CW-1:0]                dst_chan [abfc_pkg::NUM_LANES];
   logic [CW-1:0]                blend    [abfc_pkg::NUM_LANES];

   // unpack the input word
   assign src_chan[0] = req_tdata[0*CW +: CW];
   assign src_chan[1] = req_tdata[1*CW +: CW];
   assign src_chan[2] = req_tdata[2*CW +: CW];
   assign dst_chan[0] = req_tdata[4*CW +: CW];
   assign dst_chan[1] = req_tdata[5*CW +: CW];
   assign dst_chan[2] = req_tdata[6*CW +: CW];

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // channel lanes
   for (genvar i = 0; i < abfc_pkg::NUM_LANES; i++) begin : g_lane
      abfc_lane u_lane (
         .clock (clock),
         .load  (lane_load),
         .calc  (lane_calc),
         .src   (src_chan[i]),
         .dst   (dst_chan[i]),
         .alpha (req_tdata[3*CW +: CW]),
         .blend (blend[i])
      );
   end

   // byte fed to the hash unit
   always_comb begin
      case (sel_ff)
         abfc_pkg::SEL_RED:   fold_byte = blend[0];
         abfc_pkg::SEL_GREEN: fold_byte = blend[1];
         abfc_pkg::SEL_BLUE:  fold_byte = blend[2];
         abfc_pkg::SEL_ALPHA: fold_byte = abfc_pkg::ALPHA_MAX;
         default:             fold_byte = abfc_pkg::ALPHA_MAX;
      endcase
   end

   // merging stage: running checksum
   abfc_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (hash_ctrl),
      .byte_in (fold_byte),
      .hash    (hash)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         abfc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = abfc_pkg::ST_DIV;
            end
         end
         abfc_pkg::ST_DIV: begin
            state_in = abfc_pkg::ST_FOLD;
            sel_in   = abfc_pkg::SEL_RED;
         end
         abfc_pkg::ST_FOLD: begin
            sel_in = sel_ff + 2'd1;
            if (sel_ff == abfc_pkg::SEL_ALPHA) begin
               state_in = abfc_pkg::ST_DONE;
            end
         end
         abfc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = abfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abfc_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready      = 1'b0;
      lane_load       = 1'b0;
      lane_calc       = 1'b0;
      out_load        = 1'b0;
      hash_ctrl.fold  = 1'b0;
      hash_ctrl.clear = 1'b0;
      case (state_ff)
         abfc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            lane_load  = req_tvalid;
         end
         abfc_pkg::ST_DIV: begin
            lane_calc = 1'b1;
         end
         abfc_pkg::ST_FOLD: begin
            hash_ctrl.fold = 1'b1;
         end
         abfc_pkg::ST_DONE: begin
            out_load        = out_free;
            hash_ctrl.clear = out_free && last_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abfc_pkg::ST_IDLE;
         sel_ff   <= abfc_pkg::SEL_RED;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // last marker of the word in flight
   always_ff @(posedge clock) begin
      if (req_accept) begin
         last_ff <= req_tlast;
      end
   end

   // result register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= {hash, blend[2], blend[1], blend[0]};
         rsp_tlast_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

[hw/rtl/abfc_lane.sv]
// ----------------------------------------------------------------------------
// abfc_lane
// One color channel blend: (s*a + d*(255-a) + 127) / 255, two stages.
// ----------------------------------------------------------------------------
module abfc_lane (
   input  logic                        clock,
   input  logic                        load,
   input  logic                        calc,
   input  logic [abfc_pkg::CHAN_W-1:0] src,
   input  logic [abfc_pkg::CHAN_W-1:0] dst,
   input  logic [abfc_pkg::CHAN_W-1:0] alpha,
   output logic [abfc_pkg::CHAN_W-1:0] blend
);

   logic [abfc_pkg::PROD_W-1:0] prod_s_ff, prod_s_in;
   logic [abfc_pkg::PROD_W-1:0] prod_d_ff, prod_d_in;
   logic [abfc_pkg::CHAN_W-1:0] blend_ff, blend_in;
   logic [abfc_pkg::CHAN_W-1:0] inv_alpha;
   logic [abfc_pkg::PROD_W:0]   sum;
   logic [abfc_pkg::PROD_W:0]   quot_wide;

   // stage 1: the two weighted products
   always_comb begin
      inv_alpha = abfc_pkg::ALPHA_MAX - alpha;
      prod_s_in = {{abfc_pkg::CHAN_W{1'b0}}, src} * {{abfc_pkg::CHAN_W{1'b0}}, alpha};
      prod_d_in = {{abfc_pkg::CHAN_W{1'b0}}, dst} * {{abfc_pkg::CHAN_W{1'b0}}, inv_alpha};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_s_ff <= prod_s_in;
         prod_d_ff <= prod_d_in;
      end
   end

   // stage 2: rounded sum, divide by 255 as (x + (x >> 8) + 1) >> 8
   always_comb begin
      sum       = {1'b0, prod_s_ff} + {1'b0, prod_d_ff} + abfc_pkg::BLEND_ROUND;
      quot_wide = sum + (sum >> abfc_pkg::CHAN_W) + 17'd1;
      blend_in  = quot_wide[abfc_pkg::CHAN_W +: abfc_pkg::CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (calc) begin
         blend_ff <= blend_in;
      end
   end

   assign blend = blend_ff;

endmodule

[hw/rtl/abfc_hash.sv]
// ----------------------------------------------------------------------------
// abfc_hash
// Running FNV-1a 64 accumulator, one byte folded per cycle while fold is set.
// ----------------------------------------------------------------------------
module abfc_hash (
   input  logic                             clock,
   input  logic                             reset,
   input  abfc_pkg::abfc_hash_ctrl_type     ctrl,
   input  logic [abfc_pkg::CHAN_W-1:0]      byte_in,
   output logic [abfc_pkg::HASH_W-1:0]      hash
);

   logic [abfc_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [abfc_pkg::HASH_W-1:0] mixed;
   logic [abfc_pkg::HASH_W-1:0] folded;

   // xor in the byte, then multiply by 2^40 + 0x1b3 as shifts and adds
   always_comb begin
      mixed  = hash_ff ^ {{(abfc_pkg::HASH_W - abfc_pkg::CHAN_W){1'b0}}, byte_in};
      folded = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
             + (mixed << 4) + (mixed << 1) + mixed;
   end

   // next accumulator value
   always_comb begin
      hash_in = hash_ff;
      if (ctrl.clear) begin
         hash_in = abfc_pkg::FNV_OFFSET_BASIS;
      end else if (ctrl.fold) begin
         hash_in = folded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= abfc_pkg::FNV_OFFSET_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

[hw/rtl/abfc_checker.sv]
// ----------------------------------------------------------------------------
// abfc_checker
// Port-level checks for the alpha blend / checksum block.
// ----------------------------------------------------------------------------
module abfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic [abfc_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tlast,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [abfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   // one word in work at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a word is in work");

   // a new result only ever comes from a word in work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared with no word in work");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind alpha_blend_fnv_checksum abfc_checker u_abfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the alpha blend / FNV-1a 64 checksum block.
// ----------------------------------------------------------------------------
// Pixel pairs go in on the req stream and blended pixels come back on the
// rsp stream. A local predictor blends each channel, folds R, G, B and 255
// into its own copy of the running hash and queues the expected word; every
// rsp word is compared field by field with the oldest entry. Directed images
// cover alpha and channel extremes and single-pixel images, then random
// images of mixed length follow with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
   import abfc_pkg::*;

   localparam int CLOCK_PERIOD        = 8;
   localparam int RESET_CYCLES        = 9;
   localparam int RANDOM_IMAGE_PIXELS = 370;
   localparam int LOOSE_FLAG_PIXELS   = 70;
   localparam int DRAIN_CYCLES        = 24;
   localparam int unsigned CYCLE_LIMIT = 250000;
   localparam int MAX_REPORTS         = 10;
   localparam logic [HASH_W-1:0] FNV_PRIME_64 = 64'd1099511628211;

   typedef struct packed {
      logic [CHAN_W-1:0] src_red;
      logic [CHAN_W-1:0] src_green;
      logic [CHAN_W-1:0] src_blue;
      logic [CHAN_W-1:0] src_alpha;
      logic [CHAN_W-1:0] dst_red;
      logic [CHAN_W-1:0] dst_green;
      logic [CHAN_W-1:0] dst_blue;
      logic              last_pixel;
   } pixel_pair_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [HASH_W-1:0] running_hash;
      logic              image_done;
   } blend_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_LONG,
      STALL_TOGGLE
   } stall_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   logic [HASH_W-1:0] checksum_state = FNV_OFFSET_BASIS;
   blend_result_type  expected_blends[$];
   int                pixels_sent   = 0;
   int                images_sent   = 0;
   int                words_checked = 0;
   int                mismatches    = 0;
   int                burst_left    = 0;
   int unsigned       cycle_count   = 0;
   stall_mode_type    stall_mode    = STALL_NONE;
   logic [5:0]        stall_phase   = '0;

   alpha_blend_fnv_checksum i_dut (
      .clock      (clock),
      .reset      (reset),
      // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),   // last_pixel
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // out_red, out_green, out_blue, running_hash
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),   // image_done
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // rounded blend of one channel
   function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] s,
                                                       input logic [CHAN_W-1:0] d,
                                                       input logic [CHAN_W-1:0] a);
      logic [PROD_W:0] sum;
      sum = {9'd0, s} * {9'd0, a} + {9'd0, d} * {9'd0, ALPHA_MAX - a} + 17'd127;
      return CHAN_W'(sum / 17'd255);
   endfunction

   // one fnv-1a step: xor the byte in, multiply mod 2^64
   function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                   input logic [CHAN_W-1:0] b);
      return (h ^ {{(HASH_W - CHAN_W){1'b0}}, b}) * FNV_PRIME_64;
   endfunction

   // expected word for one pixel; advances the local checksum
   function automatic blend_result_type predict_blend(input pixel_pair_type px);
      blend_result_type res;
      logic [HASH_W-1:0] h;
      res.out_red   = blend_channel(px.src_red, px.dst_red, px.src_alpha);
      res.out_green = blend_channel(px.src_green, px.dst_green, px.src_alpha);
      res.out_blue  = blend_channel(px.src_blue, px.dst_blue, px.src_alpha);
      h = fold_byte(checksum_state, res.out_red);
      h = fold_byte(h, res.out_green);
      h = fold_byte(h, res.out_blue);
      h = fold_byte(h, ALPHA_MAX);
      res.running_hash = h;
      res.image_done   = px.last_pixel;
      checksum_state   = px.last_pixel ? FNV_OFFSET_BASIS : h;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic pixel_pair_type make_pixel(input int sr, input int sg, input int sb,
                                                 input int sa, input int dr, input int dg,
                                                 input int db, input bit last);
      pixel_pair_type px;
      px.src_red    = CHAN_W'(sr);
      px.src_green  = CHAN_W'(sg);
      px.src_blue   = CHAN_W'(sb);
      px.src_alpha  = CHAN_W'(sa);
      px.dst_red    = CHAN_W'(dr);
      px.dst_green  = CHAN_W'(dg);
      px.dst_blue   = CHAN_W'(db);
      px.last_pixel = last;
      return px;
   endfunction

   // byte leaning toward 0 and 255
   function automatic int random_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 0;
      if (pick == 1) return 255;
      return $urandom_range(0, 255);
   endfunction

   function automatic pixel_pair_type random_pixel(input bit last);
      return make_pixel(random_byte(), random_byte(), random_byte(), random_byte(),
                        random_byte(), random_byte(), random_byte(), last);
   endfunction

   // present one word and hold it until taken; valid stays high afterwards
   task automatic send_pixel(input pixel_pair_type px);
      req_tdata  <= {px.dst_blue, px.dst_green, px.dst_red, px.src_alpha,
                     px.src_blue, px.src_green, px.src_red};
      req_tlast  <= px.last_pixel;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_blends.push_back(predict_blend(px));
      pixels_sent++;
      if (px.last_pixel) images_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // bursts of random length, separated by random gaps when idling is allowed
   task automatic pace_sender(input bit allow_idle);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (allow_idle) idle_for($urandom_range(0, 12));
      end
      burst_left--;
   endtask

   // ---------------------------------------------------------------- tests

   // first word after reset closes its image at once
   task automatic test_single_pixel_image();
      send_pixel(make_pixel(200, 100, 50, 128, 10, 20, 30, 1'b1));
      send_pixel(make_pixel(255, 0, 255, 0, 0, 255, 0, 1'b1));
   endtask

   // alpha 0 gives the destination, alpha 255 the source
   task automatic test_alpha_extremes();
      send_pixel(make_pixel(255, 255, 255, 0, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(0, 0, 0, 0, 255, 255, 255, 1'b0));
      send_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 255, 1'b0));
      send_pixel(make_pixel(18, 52, 86, 0, 171, 205, 239, 1'b0));
      send_pixel(make_pixel(18, 52, 86, 255, 171, 205, 239, 1'b1));
   endtask

   // near-extreme alpha, rounding midpoints and all-zero / all-one words
   task automatic test_channel_extremes();
      send_pixel(make_pixel(255, 0, 255, 1, 0, 255, 0, 1'b0));
      send_pixel(make_pixel(255, 0, 255, 254, 0, 255, 0, 1'b0));
      send_pixel(make_pixel(255, 255, 255, 128, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(0, 0, 0, 128, 255, 255, 255, 1'b0));
      send_pixel(make_pixel(255, 255, 255, 127, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 1'b0));
      send_pixel(make_pixel(170, 85, 15, 127, 85, 170, 240, 1'b0));
      send_pixel(make_pixel(1, 128, 254, 200, 254, 127, 1, 1'b1));
   endtask

   // whole images with random content, mostly short, a few long
   task automatic test_random_images();
      int budget;
      int len;
      bit allow_idle;
      budget = RANDOM_IMAGE_PIXELS;
      while (budget > 0) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
         allow_idle = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < len; i++) begin
            pace_sender(allow_idle);
            send_pixel(random_pixel(i == len - 1));
         end
         budget -= len;
      end
   endtask

   // last flag set at random, leaving an image open at the end
   task automatic test_loose_last_flags();
      for (int i = 0; i < LOOSE_FLAG_PIXELS; i++) begin
         pace_sender(1'b1);
         send_pixel(random_pixel($urandom_range(0, 3) == 0));
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_single_pixel_image();
      test_alpha_extremes();
      test_channel_extremes();
      test_random_images();
      test_loose_last_flags();
      req_tvalid <= 1'b0;
      while (expected_blends.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d pixels closing %0d images, checked %0d result words",
               pixels_sent, images_sent, words_checked);
      $display("alpha 0/255 and channel extremes, bursty input, stalled output");
      if (mismatches == 0) begin
         $display("alpha_blend_fnv_checksum: match");
      end else begin
         $display("alpha_blend_fnv_checksum: mismatch");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // receiver stall pattern, mode picked anew each time the phase counter wraps
   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '1) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_RANDOM: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         STALL_LONG: begin
            rsp_tready <= (stall_phase[3:0] == 4'hF);
         end
         default: begin
            rsp_tready <= stall_phase[0];
         end
      endcase
   end

   function automatic void compare_field(input string name, input int index,
                                         input logic [HASH_W-1:0] expected_value,
                                         input logic [HASH_W-1:0] actual_value);
      if (actual_value !== expected_value) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("word %0d %s: expected %h, got %h", index, name,
                     expected_value, actual_value);
      end
   endfunction

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin : check_results
      blend_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blends.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result word %h at cycle %0d", rsp_tdata, cycle_count);
         end else begin
            want = expected_blends.pop_front();
            compare_field("out_red", words_checked, HASH_W'(want.out_red),
                          HASH_W'(rsp_tdata[7:0]));
            compare_field("out_green", words_checked, HASH_W'(want.out_green),
                          HASH_W'(rsp_tdata[15:8]));
            compare_field("out_blue", words_checked, HASH_W'(want.out_blue),
                          HASH_W'(rsp_tdata[23:16]));
            compare_field("running_hash", words_checked, want.running_hash,
                          rsp_tdata[87:24]);
            compare_field("image_done", words_checked, HASH_W'(want.image_done),
                          HASH_W'(rsp_tlast));
            words_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_blends.size());
         $display("alpha_blend_fnv_checksum: mismatch");
         $finish;
      end
   end

endmodule
